/* hdl/iur_pkg.sv */
// Package for the image update receiver: request, result and status codes,
// transaction payload structs, and the byte-wide reflected CRC-32 step.
// No dependencies.
package iur_pkg;

	localparam logic [31:0] CRC_POLY = 32'hedb88320;
	localparam logic [31:0] CRC_INIT = 32'hffffffff;
	localparam logic [31:0] PART_SIZE_RESET = 32'd1048576;
	localparam int unsigned CFG_ADDR_W = 3;

	typedef enum logic [2:0] {
		REQ_BEGIN  = 3'd0,
		REQ_HEADER = 3'd1,
		REQ_BYTE   = 3'd2,
		REQ_VERIFY = 3'd3,
		REQ_BOOT   = 3'd4,
		REQ_ENTER  = 3'd5
	} req_t;

	typedef enum logic [2:0] {
		OP_OPEN  = 3'd0,
		OP_DATA  = 3'd1,
		OP_CHECK = 3'd2,
		OP_BOOT  = 3'd3,
		OP_ENTRY = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		CODE_OK        = 3'd0,
		CODE_BAD_STATE = 3'd1,
		CODE_RANGE     = 3'd2,
		CODE_ORDER     = 3'd3,
		CODE_CRC       = 3'd4
	} code_t;

	// register indexes on the configuration port
	localparam logic REG_PART_SIZE = 1'b0;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] image_size;
		logic [31:0] expected_crc;
		logic [31:0] chunk_offset;
		logic [7:0]  chunk_len;
		logic [7:0]  data_byte;
	} iur_in_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [2:0]  code;
		logic [31:0] value;
		logic        boot_now;
	} iur_out_t;

	// fold one byte into a reflected CRC-32, LSB first
	function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

endpackage

/* hdl/image_update_receiver_crc32.sv */
// Image update receiver top level: input register, request decode and
// state update, result register, APB configuration register.
// Depends on iur_pkg.
//
// One request transaction is accepted per cycle while in_stall is low. A
// request is captured in the input register at acceptance, then decoded and
// applied to the transfer state; its result (if any) is captured in the
// result register, which drives out_valid. Data bytes fold through an
// unrolled eight-bit CRC step, so streaming runs at one byte per cycle while
// no stalled result holds the input. in_stall rises only while the input
// register holds a request and a result held in the output register is
// stalled. partition_size sits at byte address 0 of the APB port, resets to
// 1 MiB and must be written only while the block is idle (not enforced).
module image_update_receiver_crc32 #(
	parameter logic [31:0] PART_SIZE_INIT = iur_pkg::PART_SIZE_RESET
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  iur_pkg::iur_in_t                in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output iur_pkg::iur_out_t               out_data,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [iur_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import iur_pkg::*;

	logic [31:0] part_size_q;

	logic        valid_s1;
	iur_in_t     item_s1;

	logic        active_q;
	logic        chosen_q;
	logic [31:0] ann_size_q;
	logic [31:0] count_q;
	logic [31:0] want_crc_q;
	logic [31:0] crc_q;
	logic [7:0]  pending_q;

	logic        active_d;
	logic        chosen_d;
	logic [31:0] ann_size_d;
	logic [31:0] count_d;
	logic [31:0] want_crc_d;
	logic [31:0] crc_d;
	logic [7:0]  pending_d;

	logic        res_valid;
	iur_out_t    res;
	logic        out_valid_q;
	iur_out_t    out_data_q;

	logic        advance;
	logic        reg_sel;
	logic [32:0] chunk_end;

	// configuration port
	assign pready  = 1'b1;
	assign reg_sel = paddr[CFG_ADDR_W-1];
	assign prdata  = (reg_sel == REG_PART_SIZE) ? part_size_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_size_q <= PART_SIZE_INIT;
		end else if (psel && penable && pwrite && pready && reg_sel == REG_PART_SIZE) begin
			part_size_q <= pwdata;
		end
	end

	// hold the input register while a stalled result blocks the output register
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	assign chunk_end = {1'b0, item_s1.chunk_offset} + {25'd0, item_s1.chunk_len};

	always_comb begin
		active_d   = active_q;
		chosen_d   = chosen_q;
		ann_size_d = ann_size_q;
		count_d    = count_q;
		want_crc_d = want_crc_q;
		crc_d      = crc_q;
		pending_d  = pending_q;
		res_valid  = 1'b0;
		res        = '0;
		case (item_s1.req_type)
			REQ_BEGIN: begin
				active_d   = 1'b0;
				chosen_d   = 1'b0;
				ann_size_d = '0;
				count_d    = '0;
				want_crc_d = '0;
				crc_d      = '0;
				pending_d  = '0;
				res_valid  = 1'b1;
				res.op     = OP_OPEN;
				if (item_s1.image_size == 32'd0 || item_s1.image_size > part_size_q) begin
					res.code  = CODE_RANGE;
					res.value = part_size_q;
				end else begin
					active_d   = 1'b1;
					chosen_d   = 1'b1;
					ann_size_d = item_s1.image_size;
					want_crc_d = item_s1.expected_crc;
					crc_d      = CRC_INIT;
					res.code   = CODE_OK;
					res.value  = item_s1.image_size;
				end
			end
			REQ_HEADER: begin
				res_valid = 1'b1;
				res.op    = OP_DATA;
				if (!active_q || pending_q != 8'd0) begin
					res.code = CODE_BAD_STATE;
				end else if (item_s1.chunk_offset != count_q) begin
					res.code  = CODE_ORDER;
					res.value = count_q;
				end else if (chunk_end > {1'b0, ann_size_q}) begin
					res.code = CODE_RANGE;
				end else if (item_s1.chunk_len == 8'd0) begin
					res.code  = CODE_OK;
					res.value = count_q;
				end else begin
					// chunk admitted: acknowledge after its last byte
					res_valid = 1'b0;
					pending_d = item_s1.chunk_len;
				end
			end
			REQ_BYTE: begin
				// drop bytes with no admitted chunk
				if (pending_q != 8'd0) begin
					crc_d     = crc_fold(crc_q, item_s1.data_byte);
					count_d   = count_q + 32'd1;
					pending_d = pending_q - 8'd1;
					if (pending_q == 8'd1) begin
						res_valid = 1'b1;
						res.op    = OP_DATA;
						res.code  = CODE_OK;
						res.value = count_d;
					end
				end
			end
			REQ_VERIFY: begin
				res_valid = 1'b1;
				res.op    = OP_CHECK;
				if (!active_q || count_q != ann_size_q) begin
					res.code  = CODE_BAD_STATE;
					res.value = count_q;
				end else if (~crc_q != want_crc_q) begin
					active_d = 1'b0;
					res.code = CODE_CRC;
				end else begin
					res.code  = CODE_OK;
					res.value = want_crc_q;
				end
			end
			REQ_BOOT: begin
				res_valid = 1'b1;
				res.op    = OP_BOOT;
				if (!chosen_q) begin
					res.code = CODE_BAD_STATE;
				end else begin
					res.code     = CODE_OK;
					res.boot_now = 1'b1;
				end
			end
			REQ_ENTER: begin
				res_valid = 1'b1;
				res.op    = OP_ENTRY;
				res.code  = CODE_OK;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			chosen_q   <= 1'b0;
			ann_size_q <= '0;
			count_q    <= '0;
			want_crc_q <= '0;
			crc_q      <= '0;
			pending_q  <= '0;
		end else if (valid_s1 && advance) begin
			active_q   <= active_d;
			chosen_q   <= chosen_d;
			ann_size_q <= ann_size_d;
			count_q    <= count_d;
			want_crc_q <= want_crc_d;
			crc_q      <= crc_d;
			pending_q  <= pending_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// a pending chunk always fits inside the announced image
	assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 8'd0 |-> active_q &&
			({1'b0, count_q} + {25'd0, pending_q} <= {1'b0, ann_size_q}))
		else $error("pending chunk runs past the announced image");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.boot_now |->
			out_data_q.op == OP_BOOT && out_data_q.code == CODE_OK)
		else $error("boot_now raised on a result other than a successful boot");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("held request lost while the result register was blocked");

endmodule
